### sv/u8d_pkg.sv
// shared types and constants for the utf-8 validating decoder
package u8d_pkg;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	localparam logic [1:0] ST_MORE = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	localparam logic [7:0] LEAD_E0 = 8'hE0;
	localparam logic [7:0] LEAD_ED = 8'hED;
	localparam logic [7:0] LEAD_F0 = 8'hF0;
	localparam logic [7:0] LEAD_F4 = 8'hF4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       flush;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [20:0] code_point;
	} out_item_t;

	// one classified unit, flush already folded to a zero byte
	typedef struct packed {
		logic [7:0] unit;
		logic       is_cont;
		logic       lead_bad;
		logic       lead_multi;
		logic       ge_a0;
		logic       le_9f;
		logic       ge_90;
		logic       le_8f;
	} class_t;

	typedef struct packed {
		logic   valid;
		class_t head;
	} front_if_t;

endpackage

### sv/u8d_front.sv
// front end: folds flush, classifies each unit and queues it for the decoder
module u8d_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  u8d_pkg::in_item_t   item,
	input  logic                take,
	output u8d_pkg::front_if_t  front
);

	u8d_pkg::class_t                   mem_q [u8d_pkg::QDEPTH];
	logic [u8d_pkg::QPTR_W-1:0]        wr_q;
	logic [u8d_pkg::QPTR_W-1:0]        rd_q;
	logic [u8d_pkg::QCNT_W-1:0]        cnt_q;
	logic [7:0]                        b;
	u8d_pkg::class_t                   cls;
	logic                              do_push;
	logic                              do_pop;

	always_comb begin
		b              = item.flush ? 8'h00 : item.data_byte;
		cls.unit       = b;
		cls.is_cont    = (b >= 8'h80) && (b <= 8'hBF);
		cls.lead_bad   = ((b >= 8'h80) && (b <= 8'hC1)) || (b >= 8'hF5);
		cls.lead_multi = (b >= 8'hC2);
		cls.ge_a0      = (b >= 8'hA0);
		cls.le_9f      = (b <= 8'h9F);
		cls.ge_90      = (b >= 8'h90);
		cls.le_8f      = (b <= 8'h8F);
	end

	assign full    = (cnt_q == u8d_pkg::QCNT_W'(u8d_pkg::QDEPTH));
	assign do_push = push && !full;
	assign do_pop  = take && (cnt_q != '0);

	assign front.valid = (cnt_q != '0);
	assign front.head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### sv/u8d_back.sv
// back end: sequence state, code point assembly and the result queue
module u8d_back (
	input  logic                clk,
	input  logic                arst_n,
	input  u8d_pkg::front_if_t  front,
	output logic                take,
	input  logic                pop,
	output logic                empty,
	output u8d_pkg::out_item_t  result
);

	logic                              pending_q;
	logic [7:0]                        lead_q;
	logic [7:0]                        second_q;
	logic [7:0]                        third_q;
	logic [1:0]                        seen_q;

	u8d_pkg::out_item_t                mem_q [u8d_pkg::QDEPTH];
	logic [u8d_pkg::QPTR_W-1:0]        wr_q;
	logic [u8d_pkg::QPTR_W-1:0]        rd_q;
	logic [u8d_pkg::QCNT_W-1:0]        cnt_q;

	u8d_pkg::class_t                   c;
	u8d_pkg::out_item_t                res;
	logic                              out_full;
	logic                              do_pop;
	logic                              bad2;
	logic                              store_lead;
	logic                              store_second;
	logic                              store_third;

	assign c        = front.head;
	assign out_full = (cnt_q == u8d_pkg::QCNT_W'(u8d_pkg::QDEPTH));
	assign take     = front.valid && !out_full;
	assign do_pop   = pop && !empty;
	assign empty    = (cnt_q == '0);
	assign result   = mem_q[rd_q];

	// second unit range depends on the lead
	assign bad2 = !c.is_cont
		|| ((lead_q == u8d_pkg::LEAD_E0) && !c.ge_a0)
		|| ((lead_q == u8d_pkg::LEAD_ED) && !c.le_9f)
		|| ((lead_q == u8d_pkg::LEAD_F0) && !c.ge_90)
		|| ((lead_q == u8d_pkg::LEAD_F4) && !c.le_8f);

	always_comb begin
		res.status     = u8d_pkg::ST_BAD;
		res.code_point = '0;
		store_lead     = 1'b0;
		store_second   = 1'b0;
		store_third    = 1'b0;
		if (!pending_q) begin
			priority if (c.lead_bad) begin
				res.status = u8d_pkg::ST_BAD;
			end else if (c.lead_multi) begin
				res.status = u8d_pkg::ST_MORE;
				store_lead = 1'b1;
			end else begin
				res.status     = u8d_pkg::ST_DONE;
				res.code_point = {13'd0, c.unit};
			end
		end else if (seen_q == 2'd1) begin
			priority if (bad2) begin
				res.status = u8d_pkg::ST_BAD;
			end else if (lead_q >= 8'hE0) begin
				res.status   = u8d_pkg::ST_MORE;
				store_second = 1'b1;
			end else begin
				res.status     = u8d_pkg::ST_DONE;
				res.code_point = {10'd0, lead_q[4:0], c.unit[5:0]};
			end
		end else begin
			priority if (!c.is_cont) begin
				res.status = u8d_pkg::ST_BAD;
			end else if ((seen_q == 2'd2) && (lead_q >= 8'hF0)) begin
				res.status  = u8d_pkg::ST_MORE;
				store_third = 1'b1;
			end else if (lead_q < 8'hF0) begin
				res.status     = u8d_pkg::ST_DONE;
				res.code_point = {5'd0, lead_q[3:0], second_q[5:0], c.unit[5:0]};
			end else begin
				res.status     = u8d_pkg::ST_DONE;
				res.code_point = {lead_q[2:0], second_q[5:0], third_q[5:0],
					c.unit[5:0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			lead_q    <= '0;
			second_q  <= '0;
			third_q   <= '0;
			seen_q    <= '0;
		end else if (take) begin
			// an invalid unit leaves the open sequence untouched
			if (res.status == u8d_pkg::ST_DONE) begin
				pending_q <= 1'b0;
				lead_q    <= '0;
				second_q  <= '0;
				third_q   <= '0;
				seen_q    <= '0;
			end else if (store_lead) begin
				pending_q <= 1'b1;
				lead_q    <= c.unit;
				seen_q    <= 2'd1;
			end else if (store_second) begin
				second_q <= c.unit;
				seen_q   <= 2'd2;
			end else if (store_third) begin
				third_q <= c.unit;
				seen_q  <= 2'd3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mem_q[wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (take) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({take, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### sv/utf8_validating_decoder.sv
// top level of the utf-8 validating decoder
//
//  channel | handshake         | payload                          | beat
//  --------+-------------------+----------------------------------+--------------------
//  input   | push / full       | item   (data_byte, flush)        | push && !full
//  result  | pop / empty       | result (status, code_point)      | pop && !empty
//
// one beat per cycle on each side while neither is stalled by full or empty; a result
// is registered in the classify queue and then in the result queue before its beat can come
// the decoder state update is the only per-beat loop
// reset clears both queues and the sequence state; no clearing pass
// each side holds two beats, which buffer a stall at either end before it reaches the other
module utf8_validating_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  u8d_pkg::in_item_t   item,
	input  logic                pop,
	output logic                empty,
	output u8d_pkg::out_item_t  result
);

	u8d_pkg::front_if_t front;
	logic               take;

	u8d_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.take   (take),
		.front  (front)
	);

	u8d_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.front  (front),
		.take   (take),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

endmodule
